/* design/assert_macros.svh */
// assertion macros shared by the tokenizer modules
// expects aclk and aresetn in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define TOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// overlapping implication
`define TOT_ASSERT_IMPL(label, ante, cons, msg) \
    `TOT_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define TOT_ASSERT_NEXT(label, ante, cons, msg) \
    `TOT_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* design/tot_pkg.sv */
// types, codes and constants of the schedule text tokenizer
// no dependencies
package tot_pkg;

    localparam int MAX_ITEM_CHARS = 8;
    localparam int ID_BITS        = 32;
    localparam int ITEM_BITS      = 8 * MAX_ITEM_CHARS;
    localparam int ITEM_IDX_W     = 3;
    localparam int CNT_W          = 4;
    localparam int NUM_W          = 32;
    localparam int PROD_W         = NUM_W + 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic [PROD_W-1:0] NUM_LIM = PROD_W'(1) << (ID_BITS - 1);

    localparam logic [7:0] CHAR_SEP   = 8'd32;
    localparam logic [7:0] CHAR_W     = 8'h77;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_C     = 8'h63;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    typedef enum logic [2:0] {
        PH_CMD_SKIP   = 3'd0,
        PH_CMD_TOKEN  = 3'd1,
        PH_NUM_SKIP   = 3'd2,
        PH_NUM_TOKEN  = 3'd3,
        PH_ITEM_SKIP  = 3'd4,
        PH_ITEM_TOKEN = 3'd5,
        PH_DISCARD    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_READ  = 3'd2,
        CMD_ABORT = 3'd3,
        CMD_COMIT = 3'd4,
        CMD_OTHER = 3'd5
    } cmd_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_COMMAND   = 3'd1;
    localparam logic [2:0] ERR_NO_DIGITS = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_NAME_LONG = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           op_kind;
        logic signed [31:0]   transaction;
        logic [63:0]          item_name;
        logic [3:0]           item_length;
        logic [2:0]           error_code;
    } out_word_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] character;
        logic       eot;
        logic       sep;
        logic       digit;
        logic [3:0] digit_value;
        logic       ctl_space;
        logic       plus;
        logic       minus;
        cmd_t       cmd;
    } class_t;

endpackage

/* design/tot_front.sv */
// front end: classifies each incoming byte for the tokenizer back end
// depends on tot_pkg
module tot_front import tot_pkg::*; (
    input  in_word_t word_in,
    output class_t   cls
);

    logic [7:0] ch;

    assign ch = word_in.character;

    always_comb begin
        cls             = '0;
        cls.character   = ch;
        cls.eot         = word_in.end_of_text;
        cls.sep         = (ch == CHAR_SEP);
        cls.digit       = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        cls.digit_value = ch[3:0];
        cls.ctl_space   = (ch >= CHAR_TAB) && (ch <= CHAR_CR);
        cls.plus        = (ch == CHAR_PLUS);
        cls.minus       = (ch == CHAR_MINUS);
        unique case (ch)
            CHAR_W:  cls.cmd = CMD_WRITE;
            CHAR_R:  cls.cmd = CMD_READ;
            CHAR_A:  cls.cmd = CMD_ABORT;
            CHAR_C:  cls.cmd = CMD_COMIT;
            default: cls.cmd = CMD_OTHER;
        endcase
    end

endmodule

/* design/tot_queue.sv */
// short queue of classified bytes between front and back end
// depends on tot_pkg and assert_macros.svh
`include "assert_macros.svh"

module tot_queue import tot_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output class_t head
);

    class_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TOT_ASSERT(a_count_bound, count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH), "count beyond depth")
    `TOT_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "pop from empty queue")
    `TOT_ASSERT_NEXT(a_fill_step, push && !pop, count_reg == $past(count_reg) + 1'b1, "bad fill")

endmodule

/* design/tot_back.sv */
// back end: tokenizer state machine and output register
// depends on tot_pkg and assert_macros.svh
`include "assert_macros.svh"

module tot_back import tot_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      empty,
    input  class_t    head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    phase_t               phase_reg, phase_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [NUM_W-1:0]     mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 seen_reg, seen_next;
    logic                 stopped_reg, stopped_next;
    logic                 ovf_reg, ovf_next;
    logic                 started_reg, started_next;
    logic [ITEM_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_word_reg, m_word_next;

    phase_t               ph;
    cmd_t                 cmd;
    logic [NUM_W-1:0]     mag;
    logic                 neg, seen, stopped, ovf, started;
    logic [ITEM_BITS-1:0] ibuf;
    logic [CNT_W-1:0]     cnt;
    logic [2:0]           err;
    logic                 rec;
    logic                 emit;
    logic [PROD_W-1:0]    prod;
    logic [1:0]           cmd_m1;
    logic                 in_discard;

    assign prod = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + PROD_W'(head.digit_value);

    // one classified byte through the tokenizer
    always_comb begin
        ph      = phase_reg;
        cmd     = cmd_reg;
        mag     = mag_reg;
        neg     = neg_reg;
        seen    = seen_reg;
        stopped = stopped_reg;
        ovf     = ovf_reg;
        started = started_reg;
        ibuf    = buf_reg;
        cnt     = cnt_reg;
        err     = ERR_NONE;
        rec     = 1'b0;
        if (phase_reg != PH_DISCARD) begin
            if (!head.sep) begin
                unique case (ph) inside
                    PH_CMD_SKIP: begin
                        cmd = head.cmd;
                        ph  = PH_CMD_TOKEN;
                    end
                    PH_CMD_TOKEN: begin
                        cmd = CMD_OTHER;
                    end
                    PH_NUM_SKIP, PH_NUM_TOKEN: begin
                        ph = PH_NUM_TOKEN;
                        if (!stopped) begin
                            if (!started && head.ctl_space) begin
                                started = 1'b0;
                            end else if (!started && (head.plus || head.minus)) begin
                                started = 1'b1;
                                neg     = head.minus;
                            end else if (!head.digit) begin
                                stopped = 1'b1;
                            end else begin
                                started = 1'b1;
                                seen    = 1'b1;
                                if (!ovf) begin
                                    if (prod > NUM_LIM) begin
                                        ovf = 1'b1;
                                    end else begin
                                        mag = prod[NUM_W-1:0];
                                    end
                                end
                            end
                        end
                    end
                    PH_ITEM_SKIP, PH_ITEM_TOKEN: begin
                        ph = PH_ITEM_TOKEN;
                        if (cnt >= CNT_W'(MAX_ITEM_CHARS)) begin
                            err = ERR_NAME_LONG;
                        end else begin
                            ibuf[cnt[ITEM_IDX_W-1:0]*8 +: 8] = head.character;
                            cnt = cnt + 1'b1;
                        end
                    end
                    default: begin
                        ph = phase_reg;
                    end
                endcase
            end

            if (err == ERR_NONE && (head.sep || head.eot)) begin
                unique case (ph) inside
                    PH_CMD_TOKEN: begin
                        if (cmd inside {CMD_WRITE, CMD_READ, CMD_ABORT, CMD_COMIT}) begin
                            mag     = '0;
                            neg     = 1'b0;
                            seen    = 1'b0;
                            stopped = 1'b0;
                            ovf     = 1'b0;
                            started = 1'b0;
                            ibuf    = '0;
                            cnt     = '0;
                            ph      = PH_NUM_SKIP;
                        end else begin
                            err = ERR_COMMAND;
                        end
                    end
                    PH_NUM_TOKEN: begin
                        if (!seen) begin
                            err = ERR_NO_DIGITS;
                        end else if (ovf) begin
                            err = ERR_RANGE;
                        end else if (!neg && ({4'b0000, mag} > NUM_LIM - 1'b1)) begin
                            err = ERR_RANGE;
                        end else if (cmd inside {CMD_ABORT, CMD_COMIT}) begin
                            rec = 1'b1;
                            ph  = PH_CMD_SKIP;
                        end else begin
                            ph = PH_ITEM_SKIP;
                        end
                    end
                    PH_ITEM_TOKEN: begin
                        rec = 1'b1;
                        ph  = PH_CMD_SKIP;
                    end
                    default: begin
                        rec = 1'b0;
                    end
                endcase
            end

            if (err == ERR_NONE && head.eot) begin
                if (rec) begin
                    if (head.sep) begin
                        err = ERR_COMMAND;
                    end
                end else if (ph == PH_CMD_SKIP) begin
                    err = ERR_COMMAND;
                end else if (ph == PH_NUM_SKIP) begin
                    err = ERR_NO_DIGITS;
                end else if (ph == PH_ITEM_SKIP) begin
                    rec = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        ovf_next     = ovf_reg;
        started_next = started_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        if (pop) begin
            if (head.eot) begin
                phase_next   = PH_CMD_SKIP;
                cmd_next     = CMD_NONE;
                mag_next     = '0;
                neg_next     = 1'b0;
                seen_next    = 1'b0;
                stopped_next = 1'b0;
                ovf_next     = 1'b0;
                started_next = 1'b0;
                buf_next     = '0;
                cnt_next     = '0;
            end else if (phase_reg == PH_DISCARD) begin
                phase_next = PH_DISCARD;
            end else if (err != ERR_NONE) begin
                phase_next = PH_DISCARD;
            end else if (rec) begin
                phase_next   = ph;
                cmd_next     = CMD_NONE;
                mag_next     = '0;
                neg_next     = 1'b0;
                seen_next    = 1'b0;
                stopped_next = 1'b0;
                ovf_next     = 1'b0;
                started_next = 1'b0;
                buf_next     = '0;
                cnt_next     = '0;
            end else begin
                phase_next   = ph;
                cmd_next     = cmd;
                mag_next     = mag;
                neg_next     = neg;
                seen_next    = seen;
                stopped_next = stopped;
                ovf_next     = ovf;
                started_next = started;
                buf_next     = ibuf;
                cnt_next     = cnt;
            end
        end
    end

    // outputs
    assign cmd_m1     = 2'(cmd) - 2'd1;
    assign in_discard = (phase_reg == PH_DISCARD);
    assign emit       = (phase_reg != PH_DISCARD) && (rec || (err != ERR_NONE));
    assign pop        = !empty && (!m_valid_reg || m_ready);

    always_comb begin
        m_word_next            = '0;
        m_word_next.error_code = err;
        if (rec) begin
            m_word_next.op_kind     = cmd_m1;
            m_word_next.transaction = neg ? signed'(NUM_W'(0) - mag) : signed'(mag);
            if (cmd inside {CMD_WRITE, CMD_READ}) begin
                m_word_next.item_name   = ibuf;
                m_word_next.item_length = cnt;
            end
        end
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CMD_SKIP;
            cmd_reg     <= CMD_NONE;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            started_reg <= 1'b0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            seen_reg    <= seen_next;
            stopped_reg <= stopped_next;
            ovf_reg     <= ovf_next;
            started_reg <= started_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    `TOT_ASSERT_NEXT(a_eot_resets, pop && head.eot, phase_reg == PH_CMD_SKIP, "eot not reset")
    `TOT_ASSERT_NEXT(a_discard_holds, pop && in_discard && !head.eot, in_discard, "left discard")
    `TOT_ASSERT_IMPL(a_name_fits, cnt_reg > CNT_W'(MAX_ITEM_CHARS), 1'b0, "item count beyond buffer")

endmodule

/* design/transaction_op_tokenizer_core.sv */
// top level of the schedule text tokenizer: front classifier, queue, back end
// depends on tot_pkg, tot_front, tot_queue and tot_back
//
// s_word carries one byte of schedule text per word, with end_of_text on the
// last byte; m_word carries one operation record or one error report.
// both channels use valid/ready and a word moves when both are high.
// the front classifies each byte as it is taken and writes it to a four word
// queue; the back pops one word per cycle unless a result is held, runs the
// tokenizer step and loads the output register when the word completes an
// operation or finds an error. each byte is stored in the queue before use.
// throughput: one byte per cycle unless the receiver stalls; the tokenizer
// step is combinational (multiply by ten, range compare and sign fix-up).
// reset (aresetn low at a clock edge) empties the queue, drops any pending
// result and returns to waiting for a command token.
// when the receiver stalls the result is held in the output register, the
// back stops popping and the queue takes up to four more bytes before
// s_ready falls.
module transaction_op_tokenizer_core import tot_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    class_t cls;
    class_t head;
    logic   full;
    logic   empty;
    logic   pop;

    assign s_ready = !full;

    tot_front u_front (
        .word_in (s_word),
        .cls     (cls)
    );

    tot_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_data (cls),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    tot_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule
